/* hw/rtl/layered_column_span_merger_defines.svh */
// Assertion macros for the layered column span merger.
`ifndef LAYERED_COLUMN_SPAN_MERGER_DEFINES_SVH
`define LAYERED_COLUMN_SPAN_MERGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset
`define LCSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcsm: check failed");

// Next-cycle implication
`define LCSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcsm: check failed");

`else

`define LCSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/lcsm_pkg.sv */
// Shared types and constants of the layered column span merger.
`timescale 1ns / 1ps

package lcsm_pkg;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int COL_W     = 10;
	localparam int COORD_W   = 16;
	localparam int STATUS_W  = 3;
	localparam int LIDX_W    = 2;

	typedef logic [CFG_W-1:0]          cfg_t;
	typedef logic [COL_W-1:0]          col_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t top;
		coord_t bottom;
	} span_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_NEW      = 3'd0,
		STAT_MERGED   = 3'd1,
		STAT_REJECT   = 3'd2,
		STAT_OVERFLOW = 3'd3,
		STAT_CLEARED  = 3'd4
	} status_t;

	// Opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	// Register reset values
	localparam cfg_t WIDTH_RST  = 11'd320;
	localparam cfg_t HEIGHT_RST = 11'd200;

endpackage

/* hw/rtl/lcsm_cmd_if.sv */
// Command channel: span add or clear items.
`timescale 1ns / 1ps

interface lcsm_cmd_if import lcsm_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   opcode;
	col_t   column;
	coord_t span_top;
	coord_t span_bottom;

	modport source (output valid, opcode, column, span_top, span_bottom, input ready);
	modport sink   (input valid, opcode, column, span_top, span_bottom, output ready);
endinterface

/* hw/rtl/lcsm_res_if.sv */
// Result channel: one item per command.
`timescale 1ns / 1ps

interface lcsm_res_if import lcsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LIDX_W-1:0]   layer_index;
	coord_t              stored_top;
	coord_t              stored_bottom;
	col_t                range_first;
	col_t                range_last;

	modport source (output valid, status, layer_index, stored_top, stored_bottom,
		range_first, range_last, input ready);
	modport sink   (input valid, status, layer_index, stored_top, stored_bottom,
		range_first, range_last, output ready);
endinterface

/* hw/rtl/layered_column_span_merger.sv */
// Layered column span merger: the span store, its layer walk and the clearing pass.
// The spans of all layers live in one synchronous memory of LAYERS*COLS entries
// (top and bottom per entry), read one layer per cycle. An add item runs through
// accept with read, compare and write-back, and result load, with a further
// compare and read for each further layer it passes; a rejected item skips the
// compare. A clear item writes every entry back to the empty span, one per cycle.
// Any item also waits in its last cycle for as long as the previous result sits
// unaccepted in the output register. After reset the same clearing pass runs over
// all LAYERS*COLS entries before the first item is accepted; configuration writes
// are taken throughout. One item is in work at a time; a finished result waits in
// the output register while the next item enters.
`timescale 1ns / 1ps
`include "layered_column_span_merger_defines.svh"

module layered_column_span_merger import lcsm_pkg::*; #(
	parameter int COLS      = 1024,
	parameter int LAYERS    = 4,
	parameter int FRAC_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  cfg_t                 cfg_data,
	lcsm_cmd_if.sink             cmd,
	lcsm_res_if.source           res
);

	localparam int DEPTH = LAYERS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int OW    = $clog2(LAYERS + 1);
	localparam int CW    = (12 + FRAC_BITS > 17) ? 12 + FRAC_BITS : 17;
	localparam int KW    = ($clog2(COLS) + 1 > COL_W) ? $clog2(COLS) + 1 : COL_W;

	// Empty span values
	localparam coord_t EMPTY_BOT   = coord_t'(-(1 << FRAC_BITS));
	localparam int     RST_TOP_RAW = int'(HEIGHT_RST) << FRAC_BITS;
	localparam int     RST_TOP_INT = (RST_TOP_RAW > 32767) ? 32767 : RST_TOP_RAW;
	localparam coord_t RST_TOP     = coord_t'(RST_TOP_INT);
	localparam int     RST_FW      = (int'(WIDTH_RST) + 2047) % 2048;
	localparam col_t   RST_FIRST   = col_t'((RST_FW > 1023) ? 1023 : RST_FW);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INIT  = 5'b00010,
		S_CLEAR = 5'b00100,
		S_LOOK  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t          state_q;
	cfg_t            width_q;
	cfg_t            height_q;
	logic [AW-1:0]   cursor_q;
	logic [LW-1:0]   layer_q;
	logic [OW-1:0]   open_q;
	col_t            first_q [LAYERS];
	col_t            last_q  [LAYERS];
	coord_t          etop_q;

	// Item in work
	col_t            col_q;
	coord_t          top_q;
	coord_t          bot_q;
	logic [AW-1:0]   addr_q;

	// Pending result
	status_t         rstat_q;
	logic [LW-1:0]   rlayer_q;
	coord_t          rtop_q;
	coord_t          rbot_q;
	col_t            rfirst_q;
	col_t            rlast_q;

	// Output register
	logic            out_valid_q;
	status_t         out_stat_q;
	logic [LW-1:0]   out_layer_q;
	coord_t          out_top_q;
	coord_t          out_bot_q;
	col_t            out_first_q;
	col_t            out_last_q;

	// Span memory
	span_t           mem [DEPTH];
	span_t           rdata_q;
	logic            mem_we;
	logic [AW-1:0]   waddr;
	span_t           wdata;
	logic            mem_re;
	logic [AW-1:0]   raddr;

	logic            accept;
	logic            colok_in;
	logic            reject;
	logic [CW-1:0]   hfix;
	logic signed [CW-1:0] yt_ext;
	coord_t          etop_now;
	cfg_t            wm1;
	col_t            efirst_now;

	col_t            lf;
	col_t            ll;
	logic            in_rng;
	logic            is_empty;
	logic            disjoint;
	logic            next_open;
	logic            can_open;
	logic            step;
	logic            out_free;
	col_t            new_first;
	col_t            new_last;
	status_t         look_stat;
	span_t           look_span;

	// Input checks and empty values from the live registers
	assign accept     = cmd.valid & cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign colok_in   = (KW'(cmd.column) < KW'(COLS));
	assign hfix       = CW'(height_q) << FRAC_BITS;
	assign yt_ext     = CW'(cmd.span_top);
	assign reject     = !colok_in || (cmd.span_bottom < 0) || (yt_ext >= $signed(hfix));
	assign etop_now   = (hfix > CW'(32767)) ? 16'sh7FFF : coord_t'(hfix[15:0]);
	assign wm1        = width_q - 11'd1;
	assign efirst_now = wm1[10] ? 10'd1023 : wm1[9:0];
	assign out_free   = !out_valid_q || res.ready;

	// Layer compare on the word just read
	always_comb begin
		lf        = first_q[layer_q];
		ll        = last_q[layer_q];
		in_rng    = (col_q <= ll) && (col_q >= lf);
		is_empty  = rdata_q.top > rdata_q.bottom;
		disjoint  = (top_q > rdata_q.bottom) || (bot_q < rdata_q.top);
		next_open = (OW'(layer_q) + OW'(1)) < open_q;
		can_open  = open_q < OW'(LAYERS);
		step      = in_rng && !is_empty && disjoint && (next_open || can_open);

		new_first = lf;
		new_last  = ll;
		if (!in_rng) begin
			if (lf > ll) begin
				new_first = col_q;
				new_last  = col_q;
			end else if (col_q > ll) begin
				new_last = col_q;
			end else begin
				new_first = col_q;
			end
		end

		look_span.top    = top_q;
		look_span.bottom = bot_q;
		look_stat        = STAT_NEW;
		if (in_rng && !is_empty) begin
			if (disjoint) begin
				look_stat = STAT_OVERFLOW;
				look_span = rdata_q;
			end else begin
				look_stat        = STAT_MERGED;
				look_span.top    = (top_q < rdata_q.top) ? top_q : rdata_q.top;
				look_span.bottom = (bot_q > rdata_q.bottom) ? bot_q : rdata_q.bottom;
			end
		end
	end

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_q;
		wdata  = look_span;
		unique case (state_q) inside
			S_INIT, S_CLEAR: begin
				mem_we       = 1'b1;
				waddr        = cursor_q;
				wdata.top    = etop_q;
				wdata.bottom = EMPTY_BOT;
			end
			S_LOOK: begin
				mem_we = !(in_rng && !is_empty && disjoint);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		mem_re = (accept && cmd.opcode == OP_ADD && !reject) || (state_q == S_LOOK && step);
		raddr  = accept ? AW'(cmd.column) : addr_q + AW'(COLS);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Control: sequencer, layer state, clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cursor_q    <= '0;
			layer_q     <= '0;
			open_q      <= OW'(1);
			etop_q      <= RST_TOP;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LAYERS; i++) begin
				first_q[i] <= RST_FIRST;
				last_q[i]  <= '0;
			end
		end else begin
			// output register: load a finished result, else drop an accepted one
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (accept) begin
						layer_q <= '0;
						if (cmd.opcode == OP_CLEAR) begin
							etop_q   <= etop_now;
							open_q   <= OW'(1);
							cursor_q <= '0;
							for (int i = 0; i < LAYERS; i++) begin
								first_q[i] <= efirst_now;
								last_q[i]  <= '0;
							end
							state_q <= S_CLEAR;
						end else if (reject) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_INIT, S_CLEAR: begin
					cursor_q <= cursor_q + AW'(1);
					if (cursor_q == AW'(DEPTH - 1)) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_EMIT;
					end
				end
				S_LOOK: begin
					if (step) begin
						layer_q <= layer_q + LW'(1);
						if (!next_open) begin
							open_q <= open_q + OW'(1);
						end
					end else begin
						first_q[layer_q] <= new_first;
						last_q[layer_q]  <= new_last;
						state_q          <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload, pending result and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q  <= cmd.column;
			top_q  <= cmd.span_top;
			bot_q  <= cmd.span_bottom;
			addr_q <= AW'(cmd.column);
			if (cmd.opcode == OP_CLEAR) begin
				rstat_q  <= STAT_CLEARED;
				rlayer_q <= '0;
				rtop_q   <= colok_in ? etop_now : '0;
				rbot_q   <= colok_in ? EMPTY_BOT : '0;
				rfirst_q <= efirst_now;
				rlast_q  <= '0;
			end else begin
				rstat_q  <= STAT_REJECT;
				rlayer_q <= '0;
				rtop_q   <= '0;
				rbot_q   <= '0;
				rfirst_q <= '0;
				rlast_q  <= '0;
			end
		end
		if (state_q == S_LOOK) begin
			if (step) begin
				addr_q <= addr_q + AW'(COLS);
			end else begin
				rstat_q  <= look_stat;
				rlayer_q <= layer_q;
				rtop_q   <= look_span.top;
				rbot_q   <= look_span.bottom;
				rfirst_q <= new_first;
				rlast_q  <= new_last;
			end
		end
		if (state_q == S_EMIT && out_free) begin
			out_stat_q  <= rstat_q;
			out_layer_q <= rlayer_q;
			out_top_q   <= rtop_q;
			out_bot_q   <= rbot_q;
			out_first_q <= rfirst_q;
			out_last_q  <= rlast_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_stat_q;
	assign res.layer_index   = LIDX_W'(out_layer_q);
	assign res.stored_top    = out_top_q;
	assign res.stored_bottom = out_bot_q;
	assign res.range_first   = out_first_q;
	assign res.range_last    = out_last_q;

	// Checks
	`LCSM_ASSERT_IMP(a_no_write_idle, clk, arst_n, mem_we, state_q != S_IDLE && state_q != S_EMIT)
	`LCSM_ASSERT_IMP(a_layer_open, clk, arst_n, state_q == S_LOOK, OW'(layer_q) < open_q)
	`LCSM_ASSERT_NXT(a_add_looks, clk, arst_n, accept && cmd.opcode == OP_ADD && !reject, state_q == S_LOOK)
	`LCSM_ASSERT_IMP(a_open_bound, clk, arst_n, state_q != S_INIT, open_q != '0 && open_q <= OW'(LAYERS))

endmodule

/* verif/layered_column_span_merger_checker.sv */
// Result checker of the span merger: tracks the layer store and compares every result item.
`timescale 1ns / 1ps

module layered_column_span_merger_checker import lcsm_pkg::*; #(
	parameter int COLS      = 1024,
	parameter int LAYERS    = 4,
	parameter int FRAC_BITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  cfg_t                 cfg_data,
	lcsm_cmd_if                  cmd,
	lcsm_res_if                  res,
	output int                   errors,
	output int                   outstanding,
	output int                   checked,
	output int                   merged_seen,
	output int                   overflow_seen
);

	typedef struct {
		status_t           status;
		logic [LIDX_W-1:0] layer_index;
		coord_t            stored_top;
		coord_t            stored_bottom;
		col_t              range_first;
		col_t              range_last;
	} span_result_t;

	// shadow copy of the registers and the layer store
	cfg_t         width_reg;
	cfg_t         height_reg;
	coord_t       col_top    [LAYERS][COLS];
	coord_t       col_bottom [LAYERS][COLS];
	col_t         layer_lo   [LAYERS];
	col_t         layer_hi   [LAYERS];
	int           open_layers;
	span_result_t pending_spans[$];

	// back to empty spans and empty ranges, using the current registers
	function automatic void wipe_layers();
		int         empty_top;
		logic [10:0] lo;
		empty_top = int'(height_reg) << FRAC_BITS;
		if (empty_top > 32767)
			empty_top = 32767;
		lo = width_reg - 11'd1;
		for (int l = 0; l < LAYERS; l++) begin
			for (int c = 0; c < COLS; c++) begin
				col_top[l][c]    = coord_t'(empty_top);
				col_bottom[l][c] = coord_t'(-(1 << FRAC_BITS));
			end
			layer_lo[l] = (lo > 11'd1023) ? col_t'(1023) : lo[9:0];
			layer_hi[l] = '0;
		end
		open_layers = 1;
	endfunction

	function automatic span_result_t layer_view(status_t st, int lyr, col_t col);
		span_result_t r;
		r.status        = st;
		r.layer_index   = lyr[LIDX_W-1:0];
		r.stored_top    = col_top[lyr][col];
		r.stored_bottom = col_bottom[lyr][col];
		r.range_first   = layer_lo[lyr];
		r.range_last    = layer_hi[lyr];
		return r;
	endfunction

	// applies one item to the shadow store and returns the result it must give
	function automatic span_result_t merge_span(logic op, col_t col, coord_t yt, coord_t yb);
		span_result_t r;
		int           lyr;
		int           rows_fixed;
		bit           done;
		bit           colok;
		coord_t       wt;
		coord_t       wb;
		rows_fixed = int'(height_reg) << FRAC_BITS;
		colok = int'(col) < COLS;
		lyr = 0;
		done = 1'b0;
		if (op == OP_CLEAR) begin
			wipe_layers();
			r = layer_view(STAT_CLEARED, 0, colok ? col : '0);
			// a column past the store reports no span
			if (!colok) begin
				r.stored_top = '0;
				r.stored_bottom = '0;
			end
		end else if (!colok || yb < 0 || int'(yt) >= rows_fixed) begin
			r.status = STAT_REJECT;
			r.layer_index = '0;
			r.stored_top = '0;
			r.stored_bottom = '0;
			r.range_first = '0;
			r.range_last = '0;
		end else begin
			while (!done) begin
				wt = col_top[lyr][col];
				wb = col_bottom[lyr][col];
				if (col >= layer_lo[lyr] && col <= layer_hi[lyr]) begin
					if (wt > wb) begin
						// empty column (top below bottom counts as empty)
						col_top[lyr][col] = yt;
						col_bottom[lyr][col] = yb;
						r = layer_view(STAT_NEW, lyr, col);
						done = 1'b1;
					end else if (yt > wb || yb < wt) begin
						// disjoint: next layer, opening one if allowed
						if (lyr + 1 < open_layers) begin
							lyr++;
						end else if (open_layers < LAYERS) begin
							open_layers++;
							lyr++;
						end else begin
							r = layer_view(STAT_OVERFLOW, lyr, col);
							done = 1'b1;
						end
					end else begin
						if (yt < wt)
							col_top[lyr][col] = yt;
						if (yb > wb)
							col_bottom[lyr][col] = yb;
						r = layer_view(STAT_MERGED, lyr, col);
						done = 1'b1;
					end
				end else begin
					// column outside the range: widen it and store
					if (layer_lo[lyr] > layer_hi[lyr]) begin
						layer_lo[lyr] = col;
						layer_hi[lyr] = col;
					end else if (col > layer_hi[lyr]) begin
						layer_hi[lyr] = col;
					end else begin
						layer_lo[lyr] = col;
					end
					col_top[lyr][col] = yt;
					col_bottom[lyr][col] = yb;
					r = layer_view(STAT_NEW, lyr, col);
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// registers, result compare, then prediction of the item taken at this edge
	always @(posedge clk or negedge arst_n) begin
		span_result_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			wipe_layers();
			pending_spans.delete();
			errors = 0;
			checked = 0;
			merged_seen = 0;
			overflow_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_HEIGHT)
					height_reg = cfg_data;
			end
			if (res.valid && res.ready) begin
				if (pending_spans.size() == 0) begin
					$error("result item with none pending: status %0d", res.status);
					errors++;
				end else begin
					want = pending_spans.pop_front();
					check_field("status", want.status, res.status);
					check_field("layer_index", want.layer_index, res.layer_index);
					check_field("stored_top", want.stored_top, res.stored_top);
					check_field("stored_bottom", want.stored_bottom, res.stored_bottom);
					check_field("range_first", want.range_first, res.range_first);
					check_field("range_last", want.range_last, res.range_last);
					checked++;
					if (want.status == STAT_MERGED)
						merged_seen++;
					if (want.status == STAT_OVERFLOW)
						overflow_seen++;
				end
			end
			if (cmd.valid && cmd.ready)
				pending_spans.push_back(merge_span(cmd.opcode, cmd.column,
					cmd.span_top, cmd.span_bottom));
		end
		outstanding = pending_spans.size();
	end

endmodule

/* verif/layered_column_span_merger_tb.sv */
// Testbench top of the span merger: clock, reset, register writes, item traffic and verdict.
`timescale 1ns / 1ps

module layered_column_span_merger_tb import lcsm_pkg::*; ();

	localparam int COLS      = 1024;
	localparam int LAYERS    = 4;
	localparam int FRAC_BITS = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	cfg_t                 cfg_data;

	lcsm_cmd_if cmd_ch ();
	lcsm_res_if res_ch ();

	int   errors;
	int   outstanding;
	int   checked;
	int   merged_seen;
	int   overflow_seen;
	int   items_sent;
	int   clears_sent;
	int   settings_used;
	bit   steady;
	bit   hold_req;
	cfg_t cur_height;

	layered_column_span_merger #(
		.COLS(COLS), .LAYERS(LAYERS), .FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch)
	);

	layered_column_span_merger_checker #(
		.COLS(COLS), .LAYERS(LAYERS), .FRAC_BITS(FRAC_BITS)
	) span_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch), .errors(errors),
		.outstanding(outstanding), .checked(checked), .merged_seen(merged_seen),
		.overflow_seen(overflow_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit: several times the slowest correct run
	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				held = 1'b1;
			end
			res_ch.ready <= steady || ($urandom_range(99) >= 26);
		end
	end

	// offer one item, with random gaps before it, and wait until it is taken
	task automatic send_item(input logic op, input col_t col, input coord_t top,
		input coord_t bot);
		while (!steady && $urandom_range(99) < 26) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.column <= col;
		cmd_ch.span_top <= top;
		cmd_ch.span_bottom <= bot;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (op == OP_CLEAR)
			clears_sent++;
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed spans on a few hot columns, so layers stack up and overflow
	task automatic random_spans(input int count);
		col_t   hot [6];
		int     rows_fixed;
		int     pick;
		int     t;
		int     len;
		logic   op;
		col_t   col;
		coord_t top;
		coord_t bot;
		rows_fixed = int'(cur_height) << FRAC_BITS;
		foreach (hot[i])
			hot[i] = col_t'($urandom_range(1023));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(999);
			op = OP_ADD;
			col = ($urandom_range(99) < 70) ? hot[$urandom_range(5)] : col_t'($urandom);
			if (pick < 8) begin
				op = OP_CLEAR;
				top = coord_t'($urandom);
				bot = coord_t'($urandom);
			end else if (pick < 100) begin
				top = coord_t'($urandom);
				bot = coord_t'($urandom);
			end else begin
				t = $urandom_range(rows_fixed - 1);
				len = $urandom_range(rows_fixed / ((pick < 600) ? 24 : 6));
				top = coord_t'(t);
				// a share of inverted spans
				bot = coord_t'((pick < 140) ? t - len : t + len);
			end
			send_item(op, col, top, bot);
		end
	endtask

	initial begin
		int   w;
		int   h;
		cfg_t phase_width  [6];
		cfg_t phase_height [6];
		phase_width  = '{11'd1024, 11'd1, 11'd1024, 11'd1, 11'd640, 11'd320};
		phase_height = '{11'd1024, 11'd1, 11'd1, 11'd1024, 11'd480, 11'd200};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = WIDTH_RST;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_ADD;
		cmd_ch.column = '0;
		cmd_ch.span_top = '0;
		cmd_ch.span_bottom = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		clears_sent = 0;
		settings_used = 1;
		cur_height = HEIGHT_RST;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at the reset settings (screen bottom at 3200)
		send_item(OP_ADD, 10'd0, 16'sd0, 16'sd16);
		send_item(OP_ADD, 10'd1023, -16'sd32768, 16'sd32767);
		send_item(OP_ADD, 10'd0, 16'sd8, 16'sd100);
		send_item(OP_ADD, 10'd0, 16'sd500, 16'sd600);
		send_item(OP_ADD, 10'd0, 16'sd1000, 16'sd1100);
		send_item(OP_ADD, 10'd0, 16'sd2000, 16'sd2100);
		send_item(OP_ADD, 10'd0, 16'sd3000, 16'sd3100);
		send_item(OP_ADD, 10'd0, 16'sd50, 16'sd3199);
		send_item(OP_ADD, 10'd3, 16'sd10, -16'sd1);
		send_item(OP_ADD, 10'd3, 16'sd10, -16'sd32768);
		send_item(OP_ADD, 10'd3, 16'sd3200, 16'sd3300);
		send_item(OP_ADD, 10'd3, 16'sd32767, 16'sd32767);
		send_item(OP_ADD, 10'd3, 16'sd3199, 16'sd3199);
		send_item(OP_ADD, 10'd3, 16'sd50, 16'sd40);
		send_item(OP_ADD, 10'd7, 16'sd300, 16'sd200);
		send_item(OP_ADD, 10'd7, 16'sd250, 16'sd250);
		send_item(OP_ADD, 10'd7, 16'sd100, 16'sd400);
		send_item(OP_CLEAR, 10'd1023, 16'sd0, 16'sd0);
		send_item(OP_ADD, 10'd512, 16'sd20, 16'sd30);
		send_item(OP_ADD, 10'd200, 16'sd20, 16'sd30);
		send_item(OP_ADD, 10'd900, 16'sd20, 16'sd30);
		send_item(OP_CLEAR, 10'd0, 16'sd0, 16'sd0);
		drain_results();

		// output held off for a long stretch while items keep coming
		hold_req = 1'b1;
		random_spans(180);
		drain_results();

		// one phase per register setting, extremes first
		for (int p = 0; p < 6; p++) begin
			w = phase_width[p];
			h = phase_height[p];
			if (p == 5) begin
				w = $urandom_range(1024, 1);
				h = $urandom_range(1024, 1);
			end
			write_reg(REG_WIDTH, cfg_t'(w));
			write_reg(REG_HEIGHT, cfg_t'(h));
			cur_height = cfg_t'(h);
			settings_used++;
			drain_results();
			// one phase keeps the empty values of the previous setting
			if (p != 2)
				send_item(OP_CLEAR, col_t'($urandom), coord_t'($urandom), coord_t'($urandom));
			steady = (p == 3);
			if (p == 4) begin
				random_spans(100);
				drain_results();
				random_spans(105);
			end else begin
				random_spans(205);
			end
			drain_results();
			steady = 1'b0;
		end

		repeat (20) @(negedge clk);
		$display("%0d items sent (%0d clears) across %0d register settings, %0d results checked",
			items_sent, clears_sent, settings_used, checked);
		$display("%0d merges and %0d layer overflows predicted, %0d mismatches",
			merged_seen, overflow_seen, errors);
		if (errors == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
